[hw/rtl/wlpc_pkg.sv]
// Package for the weighted line-point chi-square block: types, widths and codes.
// Used by wlpc_ctrl, wlpc_dp and weighted_line_point_chi2_sum.
`default_nettype none
package wlpc_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 31;

    // Partial products per square, one per cycle on 32x32 multipliers.
    localparam int unsigned MUL_PARTS = 4;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_X0 = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_AX = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_Y0 = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_AY = 2'd3;

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_ACC   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;   // take the input item
        logic       prep;      // form cross product and norm
        logic       load;      // set up the division of one term
        logic       mul;       // add one partial product of the squares
        logic       step;      // one restoring division step
        logic       acc;       // add the finished term
        logic       finish;    // bump count, emit on last
        logic [1:0] term;      // which axis
        logic [1:0] part;      // which partial product
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic zero_err;
        logic last;
    } t_stat;

endpackage
`default_nettype wire

[hw/rtl/weighted_line_point_chi2_sum.sv]
// Top level of the weighted line-point chi-square block.
// Instantiates wlpc_ctrl and wlpc_dp; uses wlpc_pkg.
//
// Points arrive on the s_axis channel (tdata: point_x, point_y, point_z,
// err_x, err_y, err_z; tlast: last_point). Each point is divided into three
// chi-square terms on one shared restoring divider of 128 + FRAC_BITS steps.
// Each term is set up, builds its squares from four partial products, runs
// the divide steps and is accumulated; a point with a zero error skips the
// divisions. The divider length sets the throughput; one point is handled
// at a time.
// On a point with tlast the totals appear on m_axis (tdata: chi2_sum,
// point_count, zero_error_seen, sum_saturated) once the point is finished,
// and the running state clears.
// The result waits in an output register; the next point is taken meanwhile,
// and only a following last point stalls until the result is taken.
// Reset (synchronous, active low) clears the line registers and all sums.
// The user must write configuration through i_cfg_we / i_cfg_idx / i_cfg_data
// only while idle; the block itself does not enforce it.
`default_nettype none
module weighted_line_point_chi2_sum #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_idx,
    input  wire  [30:0]  i_cfg_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64], err_x[126:96],
    // err_y[157:127], err_z[188:158], zero fill to 192
    input  wire  [191:0] s_axis_tdata,
    input  wire          s_axis_tlast,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // chi2_sum[63:0], point_count[79:64], zero_error_seen[80],
    // sum_saturated[81], zero fill to 88
    output logic [87:0]  m_axis_tdata
);
    wlpc_pkg::t_cmd  w_cmd;
    wlpc_pkg::t_stat w_stat;
    logic            w_fire;
    logic [63:0]     w_sum;
    logic [15:0]     w_cnt;
    logic            w_zero, w_sat;

    assign w_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata = {6'd0, w_sat, w_zero, w_cnt, w_sum};

    wlpc_ctrl #(.DIV_STEPS(128 + FRAC_BITS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_fire),
        .i_out_busy(m_axis_tvalid), .i_stat(w_stat),
        .o_in_ready(s_axis_tready), .o_cmd(w_cmd)
    );

    wlpc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_px(s_axis_tdata[31:0]), .i_py(s_axis_tdata[63:32]),
        .i_pz(s_axis_tdata[95:64]), .i_ex(s_axis_tdata[126:96]),
        .i_ey(s_axis_tdata[157:127]), .i_ez(s_axis_tdata[188:158]),
        .i_last(s_axis_tlast), .i_cmd(w_cmd), .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid), .o_sum(w_sum), .o_count(w_cnt),
        .o_zero(w_zero), .o_sat(w_sat), .o_stat(w_stat)
    );
endmodule
`default_nettype wire

[hw/rtl/wlpc_ctrl.sv]
// Controller of the weighted line-point chi-square block.
// Sequences capture, preparation, three divisions (skipped on a zero error) and output; uses wlpc_pkg.
`default_nettype none
module wlpc_ctrl #(
    parameter int unsigned DIV_STEPS = 144
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_fire,
    input  wire              i_out_busy,
    input  wlpc_pkg::t_stat  i_stat,
    output logic             o_in_ready,
    output wlpc_pkg::t_cmd   o_cmd
);
    localparam int unsigned CntW = $clog2(DIV_STEPS + 1);

    wlpc_pkg::t_state r_state, n_state;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic [1:0]       r_term, n_term;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_term  = r_term;
        o_cmd   = '0;
        o_cmd.term = r_term;
        o_cmd.capture = i_in_fire;
        o_in_ready = (r_state == wlpc_pkg::S_IDLE);
        unique case (r_state)
            wlpc_pkg::S_IDLE: begin
                if (i_in_fire) n_state = wlpc_pkg::S_PREP;
            end
            wlpc_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                n_term = 2'd0;
                n_state = i_stat.zero_err ? wlpc_pkg::S_OUT : wlpc_pkg::S_LOAD;
            end
            wlpc_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt = '0;
                n_state = wlpc_pkg::S_MUL;
            end
            wlpc_pkg::S_MUL: begin
                // Build both squares one partial product at a time.
                o_cmd.mul = 1'b1;
                o_cmd.part = r_cnt[1:0];
                if (r_cnt == CntW'(wlpc_pkg::MUL_PARTS - 1)) begin
                    n_cnt = '0;
                    n_state = wlpc_pkg::S_DIV;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            wlpc_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CntW'(DIV_STEPS - 1)) n_state = wlpc_pkg::S_ACC;
            end
            wlpc_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
                n_term = r_term + 2'd1;
                n_state = (r_term == 2'd2) ? wlpc_pkg::S_OUT : wlpc_pkg::S_LOAD;
            end
            wlpc_pkg::S_OUT: begin
                // On a last point, wait until a previous result has been taken.
                if (!(i_stat.last && i_out_busy)) begin
                    o_cmd.finish = 1'b1;
                    n_state = wlpc_pkg::S_IDLE;
                end
            end
            default: n_state = wlpc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wlpc_pkg::S_IDLE;
            r_cnt   <= '0;
            r_term  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_term  <= n_term;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/wlpc_dp.sv]
// Datapath of the weighted line-point chi-square block: cross product,
// shared restoring divider, saturating accumulator and result register. Uses wlpc_pkg.
`default_nettype none
module wlpc_dp #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire  [1:0]       i_cfg_idx,
    input  wire  [30:0]      i_cfg_data,
    input  wire  [31:0]      i_px,
    input  wire  [31:0]      i_py,
    input  wire  [31:0]      i_pz,
    input  wire  [30:0]      i_ex,
    input  wire  [30:0]      i_ey,
    input  wire  [30:0]      i_ez,
    input  wire              i_last,
    input  wlpc_pkg::t_cmd   i_cmd,
    input  wire              i_out_ready,
    output logic             o_out_valid,
    output logic [63:0]      o_sum,
    output logic [15:0]      o_count,
    output logic             o_zero,
    output logic             o_sat,
    output wlpc_pkg::t_stat  o_stat
);
    localparam int unsigned NumW = 128;
    localparam int unsigned RemW = 127;

    // Line registers.
    logic signed [30:0] r_x0, r_y0;
    logic signed [20:0] r_ax, r_ay;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x0 <= '0; r_ax <= '0; r_y0 <= '0; r_ay <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wlpc_pkg::CFG_X0: r_x0 <= i_cfg_data;
                wlpc_pkg::CFG_AX: r_ax <= i_cfg_data[20:0];
                wlpc_pkg::CFG_Y0: r_y0 <= i_cfg_data;
                wlpc_pkg::CFG_AY: r_ay <= i_cfg_data[20:0];
                default: ;
            endcase
        end
    end

    // Captured item.
    logic signed [32:0] r_rx, r_ry;
    logic signed [31:0] r_rz;
    logic [30:0]        r_ex, r_ey, r_ez;
    logic               r_last;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rx <= 33'(signed'(i_px)) - 33'(r_x0);
            r_ry <= 33'(signed'(i_py)) - 33'(r_y0);
            r_rz <= signed'(i_pz);
            r_ex <= i_ex; r_ey <= i_ey; r_ez <= i_ez;
            r_last <= i_last;
        end
    end
    assign o_stat.zero_err = (r_ex == '0) || (r_ey == '0) || (r_ez == '0);
    assign o_stat.last = r_last;

    // Cross product and squared norm; each product about 33x21.
    logic signed [63:0] w_cx, w_cy, w_cz;
    logic [63:0]        w_n;
    logic signed [63:0] r_cx, r_cy, r_cz;
    logic [63:0]        r_n;
    always_comb begin
        w_cx = (64'(r_ry) <<< FRAC_BITS) - 64'(r_rz) * 64'(r_ay);
        w_cy = 64'(r_rz) * 64'(r_ax) - (64'(r_rx) <<< FRAC_BITS);
        w_cz = 64'(r_rx) * 64'(r_ay) - 64'(r_ry) * 64'(r_ax);
        w_n  = 64'(64'(r_ax) * 64'(r_ax)) + 64'(64'(r_ay) * 64'(r_ay))
             + (64'd1 << (2 * FRAC_BITS));
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_cx <= w_cx; r_cy <= w_cy; r_cz <= w_cz; r_n <= w_n;
        end
    end

    // Term selection and magnitude of the chosen cross-product component.
    logic signed [63:0] w_c;
    logic [30:0]        w_e;
    logic [63:0]        w_mag;
    always_comb begin
        unique case (i_cmd.term)
            2'd0:    begin w_c = r_cx; w_e = r_ex; end
            2'd1:    begin w_c = r_cy; w_e = r_ey; end
            default: begin w_c = r_cz; w_e = r_ez; end
        endcase
        w_mag = w_c[63] ? (64'd0 - 64'(w_c)) : 64'(w_c);
    end

    logic [NumW-1:0] r_num;
    logic [RemW:0]   r_den;
    logic [RemW:0]   r_rem;
    logic [63:0]     r_q;
    logic            r_big;
    logic [61:0]     r_esq;
    logic [RemW:0]   w_trial, w_sh;

    // The squares c^2 and n * e^2 are summed from 32x32 partial products,
    // one of each per cycle, selected by the part index (high half when set).
    logic [31:0] w_ma, w_mb, w_da, w_db;
    logic [63:0] w_pn, w_pd;
    logic [6:0]  w_pos;
    always_comb begin
        w_ma = i_cmd.part[1] ? w_mag[63:32] : w_mag[31:0];
        w_mb = i_cmd.part[0] ? w_mag[63:32] : w_mag[31:0];
        w_da = i_cmd.part[1] ? r_n[63:32] : r_n[31:0];
        w_db = i_cmd.part[0] ? {2'b00, r_esq[61:32]} : r_esq[31:0];
        w_pn = 64'(w_ma) * 64'(w_mb);
        w_pd = 64'(w_da) * 64'(w_db);
        unique case (i_cmd.part)
            2'd0:    w_pos = 7'd0;
            2'd3:    w_pos = 7'd64;
            default: w_pos = 7'd32;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep || i_cmd.acc) begin
            // Error square for the next term is ready before its load.
            unique case (i_cmd.prep ? 2'd0 : i_cmd.term + 2'd1)
                2'd0:    r_esq <= 62'(r_ex) * 62'(r_ex);
                2'd1:    r_esq <= 62'(r_ey) * 62'(r_ey);
                default: r_esq <= 62'(r_ez) * 62'(r_ez);
            endcase
        end
        if (i_cmd.load) begin
            r_num <= '0;
            r_den <= '0;
            r_rem <= '0;
            r_q   <= '0;
            r_big <= 1'b0;
        end else if (i_cmd.mul) begin
            r_num <= r_num + (128'(w_pn) << w_pos);
            r_den <= r_den + (128'(w_pd) << w_pos);
        end else if (i_cmd.step) begin
            r_num <= {r_num[NumW-2:0], 1'b0};
            r_big <= r_big | r_q[63];
            if (w_trial[RemW] == 1'b0 || w_sh >= r_den) begin
                r_rem <= w_sh - r_den;
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
    end
    assign w_sh = {r_rem[RemW-1:0], r_num[NumW-1]};
    assign w_trial = {1'b1, {RemW{1'b0}}};

    // Accumulator and flags.
    logic [63:0] r_sum;
    logic [15:0] r_cnt;
    logic        r_zf, r_sf;
    logic [64:0] w_add;
    logic [63:0] w_t;
    assign w_t   = r_big ? '1 : r_q;
    assign w_add = {1'b0, r_sum} + {1'b0, w_t};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0; r_cnt <= '0; r_zf <= 1'b0; r_sf <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            if (i_cmd.prep && o_stat.zero_err) r_zf <= 1'b1;
            if (i_cmd.acc) begin
                r_sum <= w_add[64] ? '1 : w_add[63:0];
                if (w_add[64] || r_big) r_sf <= 1'b1;
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    o_out_valid <= 1'b1;
                    o_sum   <= r_sum;
                    o_count <= (r_cnt == '1) ? r_cnt : r_cnt + 16'd1;
                    o_zero  <= r_zf;
                    o_sat   <= r_sf;
                    r_sum <= '0; r_cnt <= '0; r_zf <= 1'b0; r_sf <= 1'b0;
                end else if (r_cnt != '1) begin
                    r_cnt <= r_cnt + 16'd1;
                end
            end
        end
    end
endmodule
`default_nettype wire
